@@ hw/rtl/pat_section_parser_defines.svh @@
// Assertion macros used by the checker file of the section parser.
`ifndef PAT_SECTION_PARSER_DEFINES_SVH
`define PAT_SECTION_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define PSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define PSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/psp_pkg.sv @@
package psp_pkg;

    localparam int MAX_SECTION_BYTES = 1024;
    localparam int ADDR_W = $clog2(MAX_SECTION_BYTES);
    localparam int CNT_W = $clog2(MAX_SECTION_BYTES + 2);
    localparam int CMP_W = ((CNT_W > 12) ? CNT_W : 12) + 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTION_BYTES);
    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(3);
    localparam logic [CNT_W-1:0] FIRST_LOOP_IDX = CNT_W'(8);
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0] PAT_TABLE_ID = 8'h00;
    localparam logic [CMP_W-1:0] HDR_BYTES = CMP_W'(3);
    localparam logic [CMP_W-1:0] MIN_SECTION_LENGTH = CMP_W'(5 + 4);
    localparam logic [7:0] NO_VERSION = 8'hFF;

    typedef enum logic [3:0] {
        VERD_UPDATED     = 4'd0,
        VERD_DUPLICATE   = 4'd1,
        VERD_SHORT       = 4'd2,
        VERD_SYNTAX      = 4'd3,
        VERD_TABLE_ID    = 4'd4,
        VERD_LENGTH      = 4'd5,
        VERD_CRC         = 4'd6,
        VERD_NOT_CURRENT = 4'd7,
        VERD_TOO_LONG    = 4'd8
    } t_verdict;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       end_of_section;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] prog_num;
        logic [12:0] program_pid;
        logic [3:0]  verdict;
        logic [15:0] stream_id;
        logic [7:0]  table_version;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/psp_ram.sv @@
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/psp_sect.sv @@
module psp_sect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  psp_pkg::t_in_item  i_item,
    input  logic [7:0]         i_rd_data0,
    input  logic [7:0]         i_rd_data1,
    output psp_pkg::t_wr_req   o_wr,
    output logic               o_res_vld,
    output psp_pkg::t_out_item o_res
);
    import psp_pkg::*;

    logic             r_active_bank, n_active_bank;
    logic [CNT_W-1:0] r_prev_len, n_prev_len;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_all_match, n_all_match;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_hdr, n_hdr;
    logic [15:0]      r_pend_sid, n_pend_sid;
    logic [23:0]      r_entry, n_entry;
    logic [15:0]      r_sid, n_sid;
    logic [7:0]       r_ver, n_ver;

    logic [7:0]       w_byte;
    logic [7:0]       w_old;
    logic             w_exact;
    logic             w_in_store;
    logic             w_entry;
    logic [CMP_W-1:0] w_slen;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_cnt;
    t_verdict         w_verdict;

    assign w_byte     = i_item.section_byte;
    assign w_old      = r_active_bank ? i_rd_data0 : i_rd_data1;
    assign w_exact    = (r_count <= MAX_CNT);
    assign w_in_store = (r_count < MAX_CNT);
    assign w_idx      = CMP_W'(r_count);

    always_comb begin
        n_active_bank = r_active_bank;
        n_prev_len    = r_prev_len;
        n_count       = r_count;
        n_all_match   = r_all_match;
        n_crc         = r_crc;
        n_hdr         = r_hdr;
        n_pend_sid    = r_pend_sid;
        n_entry       = r_entry;
        n_sid         = r_sid;
        n_ver         = r_ver;
        w_entry       = 1'b0;
        w_verdict     = VERD_UPDATED;

        if (w_exact) begin
            if (!w_in_store || (r_count >= r_prev_len) || (w_old != w_byte)) begin
                n_all_match = 1'b0;
            end
            unique case (r_count)
                CNT_W'(0): n_hdr[31:24] = w_byte;
                CNT_W'(1): n_hdr[23:16] = w_byte;
                CNT_W'(2): n_hdr[15:8] = w_byte;
                CNT_W'(3): n_pend_sid[15:8] = w_byte;
                CNT_W'(4): n_pend_sid[7:0] = w_byte;
                CNT_W'(5): n_hdr[7:0] = w_byte;
                default: ;
            endcase
        end

        w_slen = CMP_W'({n_hdr[19:16], n_hdr[15:8]});

        if (w_exact) begin
            if ((r_count < MIN_CNT) || (w_idx < HDR_BYTES + w_slen)) begin
                n_crc = crc_byte(r_crc, w_byte);
            end
            if (r_count >= FIRST_LOOP_IDX) begin
                if (r_count[1:0] == 2'b11) begin
                    w_entry = ((w_idx + CMP_W'(1)) < w_slen);
                end else begin
                    n_entry = {r_entry[15:0], w_byte};
                end
            end
            n_count = r_count + CNT_W'(1);
        end

        w_cnt = CMP_W'(n_count);

        if (i_item.end_of_section) begin
            priority if (n_count < MIN_CNT) begin
                w_verdict = VERD_SHORT;
            end else if (n_count > MAX_CNT) begin
                w_verdict = VERD_TOO_LONG;
            end else if ((n_count == r_prev_len) && n_all_match) begin
                w_verdict = VERD_DUPLICATE;
            end else if (!n_hdr[23]) begin
                w_verdict = VERD_SYNTAX;
            end else if (n_hdr[31:24] != PAT_TABLE_ID) begin
                w_verdict = VERD_TABLE_ID;
            end else if ((HDR_BYTES + w_slen > w_cnt) || (w_slen < MIN_SECTION_LENGTH)) begin
                w_verdict = VERD_LENGTH;
            end else if (n_crc != 32'h0000_0000) begin
                w_verdict = VERD_CRC;
            end else if (!n_hdr[0]) begin
                w_verdict = VERD_NOT_CURRENT;
            end else begin
                w_verdict     = VERD_UPDATED;
                n_sid         = n_pend_sid;
                n_ver         = {3'b000, n_hdr[5:1]};
                n_prev_len    = n_count;
                n_active_bank = ~r_active_bank;
            end
            n_count     = '0;
            n_all_match = 1'b1;
            n_crc       = CRC_INIT;
            n_hdr       = '0;
            n_pend_sid  = '0;
            n_entry     = '0;
        end
    end

    always_comb begin
        o_res = '0;
        if (i_item.end_of_section) begin
            o_res.result_kind   = 1'b1;
            o_res.verdict       = w_verdict;
            o_res.stream_id     = n_sid;
            o_res.table_version = n_ver;
            o_res.last          = 1'b1;
        end else begin
            o_res.prog_num    = r_entry[23:8];
            o_res.program_pid = {r_entry[4:0], w_byte};
        end
    end

    assign o_res_vld = i_item.end_of_section || w_entry;

    // The compare reads the inactive bank while the write goes to the active one, so the two
    // ports never meet on one entry.
    assign o_wr.en   = i_fire && w_in_store;
    assign o_wr.bank = r_active_bank;
    assign o_wr.addr = r_count[ADDR_W-1:0];
    assign o_wr.data = w_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bank <= 1'b0;
            r_prev_len    <= '0;
            r_count       <= '0;
            r_all_match   <= 1'b1;
            r_crc         <= CRC_INIT;
            r_hdr         <= '0;
            r_pend_sid    <= '0;
            r_entry       <= '0;
            r_sid         <= '0;
            r_ver         <= NO_VERSION;
        end else if (i_fire) begin
            r_active_bank <= n_active_bank;
            r_prev_len    <= n_prev_len;
            r_count       <= n_count;
            r_all_match   <= n_all_match;
            r_crc         <= n_crc;
            r_hdr         <= n_hdr;
            r_pend_sid    <= n_pend_sid;
            r_entry       <= n_entry;
            r_sid         <= n_sid;
            r_ver         <= n_ver;
        end
    end

endmodule

@@ hw/rtl/pat_section_parser.sv @@
// A taken item is registered in r_s1_item; its result goes to r_out_item when that stage fires.
// Throughput: one item per cycle unless the output stalls, set by the compare-and-write of the
// two-bank section store, read at the input stage and written back in the following stage.
// Reset: synchronous, active low; clears all control state and the stored stream id and version.
// The section store is not cleared: its entries are compared only after they have been written.
module pat_section_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  psp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output psp_pkg::t_out_item o_out_item
);
    import psp_pkg::*;

    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_s1_vld, n_s1_vld;
    t_in_item         r_s1_item;
    logic             r_out_vld, n_out_vld;
    t_out_item        r_out_item;

    logic             w_accept;
    logic             w_s1_fire;
    t_wr_req          w_wr;
    logic             w_res_vld;
    t_out_item        w_res;
    logic [7:0]       w_rd_data [2];

    assign w_s1_fire = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_s1_fire;
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_idx = r_idx;
        if (w_accept) begin
            if (i_in_item.end_of_section) begin
                n_idx = '0;
            end else if (r_idx <= MAX_CNT) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
        n_s1_vld = w_accept || (r_s1_vld && !w_s1_fire);
        if (w_s1_fire) begin
            n_out_vld = w_res_vld;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        psp_ram #(
            .WIDTH (8),
            .DEPTH (MAX_SECTION_BYTES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr.en && (w_wr.bank == 1'(g))),
            .i_waddr (w_wr.addr),
            .i_wdata (w_wr.data),
            .i_re    (w_accept),
            .i_raddr (r_idx[ADDR_W-1:0]),
            .o_rdata (w_rd_data[g])
        );
    end

    psp_sect u_sect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_s1_fire),
        .i_item     (r_s1_item),
        .i_rd_data0 (w_rd_data[0]),
        .i_rd_data1 (w_rd_data[1]),
        .o_wr       (w_wr),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= i_in_item;
        end
        if (w_s1_fire) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

@@ hw/rtl/psp_checker.sv @@
`include "pat_section_parser_defines.svh"

module psp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input psp_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input psp_pkg::t_out_item o_out_item
);
    import psp_pkg::*;

    `PSP_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result item changed while stalled")
    `PSP_ASSERT_IMP(a_last_kind, o_out_valid, o_out_item.last == o_out_item.result_kind, "last does not match the result kind")
    `PSP_ASSERT_IMP(a_verdict_fields, o_out_valid && o_out_item.result_kind, (o_out_item.verdict <= VERD_TOO_LONG) && (o_out_item.prog_num == 16'd0) && (o_out_item.program_pid == 13'd0), "malformed verdict item")
    `PSP_ASSERT_IMP(a_version_range, o_out_valid && o_out_item.result_kind, (o_out_item.table_version <= 8'd31) || (o_out_item.table_version == NO_VERSION), "stored version out of range")

endmodule

bind pat_section_parser psp_checker u_psp_checker (.*);
